// ----- design/e2q_pkg.sv -----
// Shared constants, types and arithmetic helpers for the Euler-to-quaternion block.
package e2q_pkg;

  localparam int unsigned AngleBitsDef = 16;
  localparam int unsigned OutFracBitsDef = 14;
  localparam int unsigned QBits = 30;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  // Number of series steps in the sine and cosine pipelines.
  localparam int unsigned SinSteps = 7;
  localparam int unsigned CosSteps = 7;

  // Sign-magnitude Q30 value: magnitude never exceeds one.
  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } sm_t;

  // Divisor for series step j (0 is the innermost term).
  function automatic logic [8:0] sin_div(input int unsigned j);
    int unsigned k;
    k = 7 - j;
    return 9'((2 * k) * (2 * k + 1));
  endfunction

  function automatic logic [8:0] cos_div(input int unsigned j);
    int unsigned k;
    k = 8 - j;
    return 9'((2 * k - 1) * (2 * k));
  endfunction

  // Rounded Q30 product of two magnitudes.
  function automatic logic [30:0] mul_q(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + 62'(64'd1 << (QBits - 1));
    return p[60:30];
  endfunction

endpackage

// ----- design/e2q_if.sv -----
// Valid/ready channel interface carrying one payload item.
interface e2q_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/e2q_sincos.sv -----
// Pipelined half-angle sine/cosine: two register stages per series step.
module e2q_sincos #(
  parameter int unsigned AngleBits = e2q_pkg::AngleBitsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [AngleBits-1:0] angle_i,
  output e2q_pkg::sm_t         sin_o,
  output logic [30:0]          cos_o
);
  localparam int unsigned Steps = e2q_pkg::SinSteps;
  // Stage 0: half angle x and its sign.
  logic [31:0] p32;
  logic        neg;
  logic [31:0] mag32;
  logic [64:0] xprod;
  logic [30:0] x_d;

  assign p32   = 32'(angle_i) << (32 - AngleBits);
  assign neg   = p32[31];
  assign mag32 = neg ? (32'd0 - p32) : p32;
  assign xprod = 65'(mag32) * 65'(e2q_pkg::PiQ30) + 65'(64'd1 << 31);
  assign x_d   = xprod[62:32];

  logic [30:0] x_q [Steps+2];
  logic        neg_q [Steps+2];
  logic [31:0] x2_q [Steps+1];
  logic [30:0] ts_q [Steps+1];
  logic [30:0] tc_q [Steps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x_d;
      neg_q[0] <= neg;
    end
  end

  // Stage 1: x^2 (truncating); reaches about 2.47, so it needs 32 bits.
  logic [61:0] x2p;
  assign x2p = 62'(x_q[0]) * 62'(x_q[0]);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[1]   <= x_q[0];
      neg_q[1] <= neg_q[0];
      x2_q[0]  <= x2p[61:30];
      ts_q[0]  <= e2q_pkg::OneQ30;
      tc_q[0]  <= e2q_pkg::OneQ30;
    end
  end

  // Series steps: t = 1 - ((x2*t)>>30)/d for both series.
  // First stage forms the product, second divides by reciprocal multiply.
  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam logic [8:0]  DivS = e2q_pkg::sin_div(j);
    localparam logic [8:0]  DivC = e2q_pkg::cos_div(j);
    localparam int unsigned ShS  = 32 + $clog2(DivS);
    localparam int unsigned ShC  = 32 + $clog2(DivC);
    // ceil(2^Sh / d): exact floor division of any 32-bit dividend
    localparam logic [32:0] RecS = 33'(((65'd1 << ShS) + 65'(DivS) - 65'd1) / 65'(DivS));
    localparam logic [32:0] RecC = 33'(((65'd1 << ShC) + 65'(DivC) - 65'd1) / 65'(DivC));
    logic [61:0] ps, pc;
    logic [30:0] xa_q;
    logic        na_q;
    logic [31:0] x2a_q, vs_q, vc_q;
    logic [64:0] ms, mc;
    assign ps = 62'(x2_q[j]) * 62'(ts_q[j]);
    assign pc = 62'(x2_q[j]) * 62'(tc_q[j]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xa_q  <= x_q[j+1];
        na_q  <= neg_q[j+1];
        x2a_q <= x2_q[j];
        vs_q  <= ps[61:30];
        vc_q  <= pc[61:30];
      end
    end
    assign ms = 65'(vs_q) * 65'(RecS);
    assign mc = 65'(vc_q) * 65'(RecC);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j+2]   <= xa_q;
        neg_q[j+2] <= na_q;
        x2_q[j+1]  <= x2a_q;
        ts_q[j+1]  <= e2q_pkg::OneQ30 - 31'(ms >> ShS);
        tc_q[j+1]  <= e2q_pkg::OneQ30 - 31'(mc >> ShC);
      end
    end
  end

  // Final stage: sin = x*t, cos = 1 - (x2*t)/2 held at zero.
  logic [61:0] sp, cp;
  logic [31:0] sub;
  assign sp  = 62'(x_q[Steps+1]) * 62'(ts_q[Steps]);
  assign cp  = 62'(x2_q[Steps]) * 62'(tc_q[Steps]);
  assign sub = {1'b0, cp[61:31]};
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o.mag <= sp[60:30];
      sin_o.neg <= neg_q[Steps+1] && (sp[60:30] != 31'd0);
      cos_o     <= (sub > 32'(e2q_pkg::OneQ30)) ? 31'd0 : 31'(32'(e2q_pkg::OneQ30) - sub);
    end
  end
endmodule

// ----- design/e2q_combine.sv -----
// Quaternion product stages: pair products, triple products, sum and round.
module e2q_combine #(
  parameter int unsigned OutFracBits = e2q_pkg::OutFracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  e2q_pkg::sm_t           sr_i, sp_i, sy_i,
  input  logic [30:0]            cr_i, cp_i, cy_i,
  output logic [OutFracBits+1:0] q_o [4]
);
  localparam int unsigned Sh = e2q_pkg::QBits - OutFracBits;
  // Stage A: pitch*yaw products.
  e2q_pkg::sm_t cpcy_q, spsy_q, cpsy_q, spcy_q, sr_q;
  logic [30:0]  cr_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cpcy_q <= '{1'b0, e2q_pkg::mul_q(cp_i, cy_i)};
      spsy_q <= '{sp_i.neg ^ sy_i.neg, e2q_pkg::mul_q(sp_i.mag, sy_i.mag)};
      cpsy_q <= '{sy_i.neg, e2q_pkg::mul_q(cp_i, sy_i.mag)};
      spcy_q <= '{sp_i.neg, e2q_pkg::mul_q(sp_i.mag, cy_i)};
      sr_q   <= sr_i;
      cr_q   <= cr_i;
    end
  end

  // Stage B: eight signed triple products.
  function automatic logic signed [32:0] smul(input logic n, input logic [30:0] a,
                                              input e2q_pkg::sm_t b);
    logic [30:0] m;
    m = e2q_pkg::mul_q(a, b.mag);
    return (n ^ b.neg) ? -$signed({2'b0, m}) : $signed({2'b0, m});
  endfunction

  logic signed [32:0] t_q [8];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= smul(1'b0, cr_q, cpcy_q);
      t_q[1] <= smul(sr_q.neg, sr_q.mag, spsy_q);
      t_q[2] <= smul(sr_q.neg, sr_q.mag, cpcy_q);
      t_q[3] <= smul(1'b0, cr_q, spsy_q);
      t_q[4] <= smul(1'b0, cr_q, spcy_q);
      t_q[5] <= smul(sr_q.neg, sr_q.mag, cpsy_q);
      t_q[6] <= smul(1'b0, cr_q, cpsy_q);
      t_q[7] <= smul(sr_q.neg, sr_q.mag, spcy_q);
    end
  end

  // Stage C: sums.
  logic signed [33:0] s_q [4];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= 34'(t_q[0]) + 34'(t_q[1]);
      s_q[1] <= 34'(t_q[2]) - 34'(t_q[3]);
      s_q[2] <= 34'(t_q[4]) + 34'(t_q[5]);
      s_q[3] <= 34'(t_q[6]) - 34'(t_q[7]);
    end
  end

  // Stage D: round half away from zero, clamp to one.
  localparam logic [33:0] Lim = 34'(64'd1 << OutFracBits);
  for (genvar i = 0; i < 4; i++) begin : g_out
    logic        n;
    logic [33:0] m, r;
    assign n = s_q[i][33];
    assign m = n ? 34'(-s_q[i]) : 34'(s_q[i]);
    assign r = (m + 34'(64'd1 << (Sh - 1))) >> Sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_o[i] <= (OutFracBits+2)'(n ? (34'd0 - ((r > Lim) ? Lim : r))
                                     : ((r > Lim) ? Lim : r));
      end
    end
  end
endmodule

// ----- design/euler_to_quaternion_unit.sv -----
// Top level: Z-Y-X Euler angles to unit quaternion, fully pipelined.
//
// Usage:
//   in_if  (sink):   roll, pitch, yaw as signed binary angles (full scale = pi).
//   out_if (source): quat_w/x/y/z in signed Q2.OutFracBits, clamped to +/-1.
//   An item moves on a channel at a clock edge with valid and ready high.
// Pipeline: the seven series steps of the sine/cosine pipelines at two
//   stages each (product, then divide by reciprocal multiply), plus the
//   half-angle, square, final product, and four combine stages.
// Throughput: one item per cycle unless the output stalls; the whole pipe advances as one.
// Stall: when out ready is low and the last stage holds an item, the whole
//   pipe freezes (in ready low); nothing is lost or repeated. Bubbles advance
//   freely, so in ready stays high while the final stage is empty.
// Reset: rst_ni (async, active low) clears all valid bits; the data path
//   holds no reset and the block keeps no state between items.
module euler_to_quaternion_unit #(
  parameter int unsigned AngleBits   = e2q_pkg::AngleBitsDef,
  parameter int unsigned OutFracBits = e2q_pkg::OutFracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  e2q_if.sink   in_if,
  e2q_if.source out_if
);
  localparam int unsigned Lat = 2 * e2q_pkg::SinSteps + 7;

  logic en;
  logic [Lat-1:0] vld_q;

  // Advance when last stage is empty or being taken.
  assign en          = !vld_q[Lat-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_if.valid};
    end
  end

  e2q_pkg::sm_t sr, sp, sy;
  logic [30:0]  cr, cp, cy;

  e2q_sincos #(.AngleBits(AngleBits)) u_roll (
    .clk_i, .en_i(en), .angle_i(in_if.data.roll), .sin_o(sr), .cos_o(cr));
  e2q_sincos #(.AngleBits(AngleBits)) u_pitch (
    .clk_i, .en_i(en), .angle_i(in_if.data.pitch), .sin_o(sp), .cos_o(cp));
  e2q_sincos #(.AngleBits(AngleBits)) u_yaw (
    .clk_i, .en_i(en), .angle_i(in_if.data.yaw), .sin_o(sy), .cos_o(cy));

  logic [OutFracBits+1:0] q [4];
  e2q_combine #(.OutFracBits(OutFracBits)) u_comb (
    .clk_i, .en_i(en), .sr_i(sr), .sp_i(sp), .sy_i(sy),
    .cr_i(cr), .cp_i(cp), .cy_i(cy), .q_o(q));

  assign out_if.valid       = vld_q[Lat-1];
  assign out_if.data.quat_w = q[0];
  assign out_if.data.quat_x = q[1];
  assign out_if.data.quat_y = q[2];
  assign out_if.data.quat_z = q[3];

  // A stalled output freezes the whole pipe.
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(vld_q))
    else $error("pipe moved during stall");
  // Input ready is high exactly when the pipe can advance.
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == (!vld_q[Lat-1] || out_if.ready))
    else $error("ready mismatch");
  // Component quat_w never exceeds plus one.
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ($signed(q[0]) <= $signed((OutFracBits+2)'(1 << OutFracBits))))
    else $error("quat_w above one");
endmodule

// ----- sim/euler_to_quaternion_unit_tb.sv -----
// Testbench for euler_to_quaternion_unit: directed and random attitudes checked by a Q30 predictor.
`timescale 1ns / 1ps

module euler_to_quaternion_unit_tb;

  // Attitude sample; roll sits in the upper bits.
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } attitude_t;

  // Quaternion in Q2.14.
  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  localparam longint unsigned OneQ = 64'd1 << 30;
  localparam longint unsigned PiQ = 64'd3373259426;
  localparam int unsigned LatencyCycles = 21;

  // Traffic modes, stepped every 100 accepted items.
  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_SRC_IDLE,
    MODE_SINK_STALL,
    MODE_BOTH
  } traffic_mode_e;

  logic clk_i;
  logic rst_ni;

  e2q_if #(.payload_t(attitude_t)) angles_if ();
  e2q_if #(.payload_t(quat_t)) quat_if ();

  euler_to_quaternion_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (angles_if),
    .out_if (quat_if)
  );

  attitude_t     pending_angles[$];
  quat_t         expected_quats[$];
  int            accepted_cnt;
  int            mismatch_cnt;
  traffic_mode_e traffic_mode;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: half-angle sine/cosine by truncating Horner series in Q30,
  // sign-magnitude products rounded half up, then Q2.14 rounding and clamp.
  // ---------------------------------------------------------------------------
  function automatic void half_sin_cos(input logic [15:0] angle,
                                       output longint s, output longint c);
    longint unsigned p, mag, x, x2, t, sub;
    logic neg;
    p = {32'd0, angle, 16'd0};
    neg = p[31];
    mag = neg ? ((64'd1 << 32) - p) : p;   // most negative angle is -pi
    x = (mag * PiQ + (64'd1 << 31)) >> 32;
    x2 = (x * x) >> 30;
    t = OneQ;
    for (int k = 7; k >= 1; k--)
      t = OneQ - ((x2 * t) >> 30) / longint'((2 * k) * (2 * k + 1));
    s = longint'((x * t) >> 30);
    if (neg) s = -s;
    t = OneQ;
    for (int k = 8; k >= 2; k--)
      t = OneQ - ((x2 * t) >> 30) / longint'((2 * k - 1) * (2 * k));
    sub = ((x2 * t) >> 30) / 2;
    c = (sub > OneQ) ? 0 : longint'(OneQ - sub);  // cosine held at zero
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint unsigned ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [15:0] round_q14(input longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << 15)) >> 16;       // half away from zero
    if (m > (64'd1 << 14)) m = 64'd1 << 14;
    return (v < 0) ? 16'(-m) : 16'(m);
  endfunction

  function automatic quat_t predict_quat(input attitude_t a);
    longint sr, cr, sp, cp, sy, cy, cpcy, spsy, cpsy, spcy;
    quat_t q;
    half_sin_cos(a.roll, sr, cr);
    half_sin_cos(a.pitch, sp, cp);
    half_sin_cos(a.yaw, sy, cy);
    cpcy = qmul(cp, cy);
    spsy = qmul(sp, sy);
    cpsy = qmul(cp, sy);
    spcy = qmul(sp, cy);
    q.quat_w = round_q14(qmul(cr, cpcy) + qmul(sr, spsy));
    q.quat_x = round_q14(qmul(sr, cpcy) - qmul(cr, spsy));
    q.quat_y = round_q14(qmul(cr, spcy) + qmul(sr, cpsy));
    q.quat_z = round_q14(qmul(cr, cpsy) - qmul(sr, spcy));
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops the next item unless this cycle is an idle one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angles_if.valid <= 1'b0;
      angles_if.data  <= '0;
    end else if (!angles_if.valid || angles_if.ready) begin
      if (pending_angles.size() != 0 &&
          !((traffic_mode == MODE_SRC_IDLE) ? ($urandom_range(99) < 57) :
            (traffic_mode == MODE_BOTH) ? ($urandom_range(99) < 33) : 1'b0)) begin
        angles_if.valid <= 1'b1;
        angles_if.data  <= pending_angles.pop_front();
      end else begin
        angles_if.valid <= 1'b0;
      end
    end
  end

  // Input monitor: predict at the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni && angles_if.valid && angles_if.ready) begin
      expected_quats = {expected_quats, predict_quat(angles_if.data)};
      accepted_cnt <= accepted_cnt + 1;
      traffic_mode <= traffic_mode_e'(((accepted_cnt + 1) / 100) % 4);
    end
  end

  // Output side: random stall per mode, compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    quat_t exp_q;
    if (!rst_ni) begin
      quat_if.ready <= 1'b0;
    end else begin
      if (quat_if.valid && quat_if.ready) begin
        if (expected_quats.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("unexpected result %h at %0t", quat_if.data, $time);
        end else begin
          exp_q = expected_quats.pop_front();
          if (exp_q !== quat_if.data) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("mismatch: w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d (exp/act)",
                       exp_q.quat_w, quat_if.data.quat_w, exp_q.quat_x,
                       quat_if.data.quat_x, exp_q.quat_y, quat_if.data.quat_y,
                       exp_q.quat_z, quat_if.data.quat_z);
          end
        end
      end
      quat_if.ready <= (traffic_mode == MODE_SINK_STALL) ? ($urandom_range(99) >= 57) :
                       (traffic_mode == MODE_BOTH) ? ($urandom_range(99) >= 33) : 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    attitude_t a;
    logic signed [15:0] corner[6];
    angles_if.valid = 1'b0;
    angles_if.data  = '0;
    quat_if.ready   = 1'b0;
    accepted_cnt    = 0;
    mismatch_cnt    = 0;
    traffic_mode    = MODE_FREE;
    rst_ni          = 1'b0;

    // directed: zero, quarter turns, +/- pi extremes and the smallest step on each axis
    corner = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd32767, -16'sd32768, 16'sd1};
    for (int i = 0; i < 6; i++) begin
      pending_angles = {pending_angles, attitude_t'{corner[i], 16'sd0, 16'sd0}};
      pending_angles = {pending_angles, attitude_t'{16'sd0, corner[i], 16'sd0}};
      pending_angles = {pending_angles, attitude_t'{16'sd0, 16'sd0, corner[i]}};
    end
    pending_angles = {pending_angles, attitude_t'{-16'sd32768, -16'sd32768, -16'sd32768}};
    pending_angles = {pending_angles, attitude_t'{16'sd32767, 16'sd32767, 16'sd32767}};
    pending_angles = {pending_angles, attitude_t'{16'sd8192, 16'sd16384, -16'sd8192}};
    pending_angles = {pending_angles, attitude_t'{-16'sd1, -16'sd1, -16'sd1}};

    // random: mostly uniform, some clustered near the wrap points or zero
    for (int i = 0; i < 830; i++) begin
      a = 48'({$urandom(), $urandom()});
      if ($urandom_range(9) == 0) a.roll = 16'h8000 ^ 16'($urandom_range(3));
      if ($urandom_range(9) == 0) a.pitch = 16'h7FFF - 16'($urandom_range(3));
      if ($urandom_range(9) == 0) a.yaw = 16'($urandom_range(3));
      pending_angles = {pending_angles, a};
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_angles.size() == 0 && !angles_if.valid && expected_quats.size() == 0);
    repeat (LatencyCycles * 3) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_quats.size() == 0)
      $display("euler_to_quaternion_unit_tb: clean");
    else
      $display("euler_to_quaternion_unit_tb: errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("euler_to_quaternion_unit_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
design/e2q_pkg.sv
design/e2q_if.sv
design/e2q_sincos.sv
design/e2q_combine.sv
design/euler_to_quaternion_unit.sv
sim/euler_to_quaternion_unit_tb.sv
